// ===== rtl/calendar_clock_with_unix_time_assert.svh =====
// Assertion macros for the calendar clock port checks.
`ifndef CALENDAR_CLOCK_WITH_UNIX_TIME_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_UNIX_TIME_ASSERT_SVH

// Check a property while out of reset.
`define CCU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("calendar clock port check failed");

// Check a property at every edge, reset included.
`define CCU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("calendar clock reset check failed");

`endif

// ===== rtl/ccu_pkg.sv =====
package ccu_pkg;

    localparam logic [6:0]  YEAR_MAX          = 7'd99;
    localparam logic [3:0]  MONTH_MAX         = 4'd12;
    localparam logic [4:0]  HOUR_MAX          = 5'd23;
    localparam logic [5:0]  MIN_SEC_MAX       = 6'd59;
    localparam logic [15:0] DAYS_1970_TO_2000 = 16'd10957;
    localparam logic [15:0] DAYS_PER_YEAR     = 16'd365;
    localparam logic [16:0] SECS_PER_HOUR     = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN      = 17'd60;
    localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
    localparam logic [31:0] UNIX_RESET        = 32'd946684800;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_cal;

    typedef struct packed {
        t_cmd       cmd;
        t_cal       cal;
        logic [4:0] tz_hours;
    } t_in_word;

    typedef struct packed {
        t_cmd        cmd;
        t_cal        cal;
        logic [15:0] days;
        logic [31:0] tod_adj;
    } t_prep_word;

    typedef struct packed {
        t_cmd        cmd;
        t_cal        cal;
        logic [31:0] day_secs;
        logic [31:0] tod_adj;
    } t_scaled_word;

    function automatic logic [4:0] month_len(input logic [6:0] year, input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd2: begin
                len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/ccu_set_prep.sv =====
module ccu_set_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_up_valid,
    output logic               o_up_ready,
    input  ccu_pkg::t_in_word  i_word,
    output logic               o_dn_valid,
    input  logic               i_dn_ready,
    output ccu_pkg::t_prep_word o_word
);

    logic                 r_valid;
    ccu_pkg::t_prep_word  r_word;
    ccu_pkg::t_prep_word  n_word;
    ccu_pkg::t_cal        cal_c;
    logic [4:0]           mlen;
    logic [5:0]           leaps;
    logic                 leap_adj;
    logic [16:0]          tod;
    logic [16:0]          tz_secs;

    always_comb begin
        cal_c.year   = (i_word.cal.year > ccu_pkg::YEAR_MAX) ? ccu_pkg::YEAR_MAX
                                                            : i_word.cal.year;
        if (i_word.cal.month == 4'd0) begin
            cal_c.month = 4'd1;
        end else if (i_word.cal.month > ccu_pkg::MONTH_MAX) begin
            cal_c.month = ccu_pkg::MONTH_MAX;
        end else begin
            cal_c.month = i_word.cal.month;
        end
        mlen = ccu_pkg::month_len(cal_c.year, cal_c.month);
        if (i_word.cal.day == 5'd0) begin
            cal_c.day = 5'd1;
        end else if (i_word.cal.day > mlen) begin
            cal_c.day = mlen;
        end else begin
            cal_c.day = i_word.cal.day;
        end
        cal_c.hour   = (i_word.cal.hour > ccu_pkg::HOUR_MAX) ? ccu_pkg::HOUR_MAX
                                                            : i_word.cal.hour;
        cal_c.minute = (i_word.cal.minute > ccu_pkg::MIN_SEC_MAX) ? ccu_pkg::MIN_SEC_MAX
                                                                 : i_word.cal.minute;
        cal_c.second = (i_word.cal.second > ccu_pkg::MIN_SEC_MAX) ? ccu_pkg::MIN_SEC_MAX
                                                                 : i_word.cal.second;

        // leap years from 2000 up to the year before
        leaps    = 6'((8'(cal_c.year) + 8'd3) >> 2);
        leap_adj = (cal_c.month > 4'd2) && (cal_c.year[1:0] == 2'b00);

        tod     = 17'(cal_c.hour) * ccu_pkg::SECS_PER_HOUR
                + 17'(cal_c.minute) * ccu_pkg::SECS_PER_MIN
                + 17'(cal_c.second);
        tz_secs = 17'(i_word.tz_hours) * ccu_pkg::SECS_PER_HOUR;

        n_word.cmd     = i_word.cmd;
        n_word.cal     = cal_c;
        n_word.days    = ccu_pkg::DAYS_1970_TO_2000
                       + 16'(cal_c.year) * ccu_pkg::DAYS_PER_YEAR
                       + 16'(leaps)
                       + 16'(ccu_pkg::days_before(cal_c.month))
                       + 16'(leap_adj)
                       + 16'(cal_c.day) - 16'd1;
        n_word.tod_adj = 32'(tod) - 32'(tz_secs);
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_word <= n_word;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_word     = r_word;

endmodule

// ===== rtl/ccu_day_scale.sv =====
module ccu_day_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_up_valid,
    output logic                  o_up_ready,
    input  ccu_pkg::t_prep_word   i_word,
    output logic                  o_dn_valid,
    input  logic                  i_dn_ready,
    output ccu_pkg::t_scaled_word o_word
);

    logic                  r_valid;
    ccu_pkg::t_scaled_word r_word;
    ccu_pkg::t_scaled_word n_word;

    always_comb begin
        n_word.cmd      = i_word.cmd;
        n_word.cal      = i_word.cal;
        n_word.day_secs = 32'(i_word.days) * ccu_pkg::SECS_PER_DAY;
        n_word.tod_adj  = i_word.tod_adj;
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_word <= n_word;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_word     = r_word;

endmodule

// ===== rtl/ccu_cal_core.sv =====
module ccu_cal_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_up_valid,
    output logic                  o_up_ready,
    input  ccu_pkg::t_scaled_word i_word,
    output logic                  o_dn_valid,
    input  logic                  i_dn_ready,
    output ccu_pkg::t_cal         o_cal,
    output logic [31:0]           o_unix
);

    logic          r_out_valid;
    ccu_pkg::t_cal r_cal;
    ccu_pkg::t_cal n_cal;
    logic [31:0]   r_unix;
    logic [31:0]   n_unix;

    always_comb begin
        n_cal  = r_cal;
        n_unix = r_unix + 32'd1;
        unique case (i_word.cmd)
            ccu_pkg::CMD_SET: begin
                n_cal  = i_word.cal;
                n_unix = i_word.day_secs + i_word.tod_adj;
            end
            ccu_pkg::CMD_TICK: begin
                if (r_cal.second < ccu_pkg::MIN_SEC_MAX) begin
                    n_cal.second = r_cal.second + 6'd1;
                end else begin
                    n_cal.second = 6'd0;
                    if (r_cal.minute < ccu_pkg::MIN_SEC_MAX) begin
                        n_cal.minute = r_cal.minute + 6'd1;
                    end else begin
                        n_cal.minute = 6'd0;
                        if (r_cal.hour < ccu_pkg::HOUR_MAX) begin
                            n_cal.hour = r_cal.hour + 5'd1;
                        end else begin
                            n_cal.hour = 5'd0;
                            if (r_cal.day < ccu_pkg::month_len(r_cal.year, r_cal.month)) begin
                                n_cal.day = r_cal.day + 5'd1;
                            end else begin
                                n_cal.day = 5'd1;
                                if (r_cal.month < ccu_pkg::MONTH_MAX) begin
                                    n_cal.month = r_cal.month + 4'd1;
                                end else begin
                                    n_cal.month = 4'd1;
                                    n_cal.year  = (r_cal.year >= ccu_pkg::YEAR_MAX) ? 7'd0
                                                : r_cal.year + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                n_cal = r_cal;
            end
        endcase
    end

    assign o_up_ready = !r_out_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cal.year   <= 7'd0;
            r_cal.month  <= 4'd1;
            r_cal.day    <= 5'd1;
            r_cal.hour   <= 5'd0;
            r_cal.minute <= 6'd0;
            r_cal.second <= 6'd0;
            r_unix       <= ccu_pkg::UNIX_RESET;
        end else begin
            if (o_up_ready) begin
                r_out_valid <= i_up_valid;
            end
            if (o_up_ready && i_up_valid) begin
                r_cal  <= n_cal;
                r_unix <= n_unix;
            end
        end
    end

    assign o_dn_valid = r_out_valid;
    assign o_cal      = r_cal;
    assign o_unix     = r_unix;

endmodule

// ===== rtl/calendar_clock_with_unix_time.sv =====
// Calendar clock with Unix seconds count. Each input word is either a one-second
// tick (tuser low) or a set command (tuser high) carrying a date, time and
// time-zone offset in hours; every word yields one output word with the
// calendar and the 32-bit Unix count after the update. Set fields out of range
// are saturated, years run 2000 to 2099 and wrap to 2000. The block takes one
// word per cycle while the output is not stalled; a result passes in turn
// through the input register, the field saturation and day count register,
// and the day-to-seconds multiply register into the calendar state register
// that is also the output register. A stalled output holds the stages behind it.
module calendar_clock_with_unix_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // set_year, set_month, set_day, set_hour, set_minute, set_second, tz_hours
    input  logic [39:0] i_s_axis_tdata,
    // cmd
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_year, out_month, out_day, out_hour, out_minute, out_second, unix_seconds
    output logic [71:0] o_m_axis_tdata
);

    logic                  r_in_valid;
    ccu_pkg::t_in_word     r_in_word;
    ccu_pkg::t_in_word     n_in_word;
    logic                  prep_ready;
    logic                  prep_valid;
    ccu_pkg::t_prep_word   prep_word;
    logic                  scale_ready;
    logic                  scale_valid;
    ccu_pkg::t_scaled_word scale_word;
    logic                  core_ready;
    ccu_pkg::t_cal         cal;
    logic [31:0]           unix;

    always_comb begin
        n_in_word.cmd        = ccu_pkg::t_cmd'(i_s_axis_tuser);
        n_in_word.cal.year   = i_s_axis_tdata[6:0];
        n_in_word.cal.month  = i_s_axis_tdata[10:7];
        n_in_word.cal.day    = i_s_axis_tdata[15:11];
        n_in_word.cal.hour   = i_s_axis_tdata[20:16];
        n_in_word.cal.minute = i_s_axis_tdata[26:21];
        n_in_word.cal.second = i_s_axis_tdata[32:27];
        n_in_word.tz_hours   = i_s_axis_tdata[37:33];
    end

    assign o_s_axis_tready = !r_in_valid || prep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_word <= n_in_word;
        end
    end

    ccu_set_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (r_in_valid),
        .o_up_ready (prep_ready),
        .i_word     (r_in_word),
        .o_dn_valid (prep_valid),
        .i_dn_ready (scale_ready),
        .o_word     (prep_word)
    );

    ccu_day_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (prep_valid),
        .o_up_ready (scale_ready),
        .i_word     (prep_word),
        .o_dn_valid (scale_valid),
        .i_dn_ready (core_ready),
        .o_word     (scale_word)
    );

    ccu_cal_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (scale_valid),
        .o_up_ready (core_ready),
        .i_word     (scale_word),
        .o_dn_valid (o_m_axis_tvalid),
        .i_dn_ready (i_m_axis_tready),
        .o_cal      (cal),
        .o_unix     (unix)
    );

    assign o_m_axis_tdata = {7'd0, unix, cal.second, cal.minute, cal.hour,
                             cal.day, cal.month, cal.year};

endmodule

// ===== rtl/ccu_port_checker.sv =====
`include "calendar_clock_with_unix_time_assert.svh"

module ccu_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata
);

    logic out_stall;
    logic date_ok;
    logic time_ok;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign date_ok   = (o_m_axis_tdata[6:0] <= 7'd99) && (o_m_axis_tdata[10:7] != 4'd0)
                    && (o_m_axis_tdata[10:7] <= 4'd12) && (o_m_axis_tdata[15:11] != 5'd0);
    assign time_ok   = (o_m_axis_tdata[20:16] <= 5'd23) && (o_m_axis_tdata[26:21] <= 6'd59)
                    && (o_m_axis_tdata[32:27] <= 6'd59);

    `CCU_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)

    `CCU_ASSERT(a_hold, i_clk, i_rst_n, out_stall |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `CCU_ASSERT(a_date_range, i_clk, i_rst_n, o_m_axis_tvalid |-> date_ok)

    `CCU_ASSERT(a_time_range, i_clk, i_rst_n, o_m_axis_tvalid |-> time_ok)

endmodule

bind calendar_clock_with_unix_time ccu_port_checker u_ccu_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        ccu_pkg::t_cal cal;
        logic [31:0]   unix;
    } t_reading;

    typedef struct {
        ccu_pkg::t_cmd cmd;
        logic [39:0]   fields;
        bit            typed;
        t_reading      reading;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_user;
    logic [39:0] s_data;
    logic        m_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [71:0] o_m_axis_tdata;

    t_reading    rtc_now;
    t_reading    pending_readings[$];
    t_stim_row   stim_table[$];
    bit          cur_typed;
    t_reading    cur_reading;
    int          phase;
    int          errors;
    int          cycle_cnt;

    calendar_clock_with_unix_time u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [39:0] pack_fields(int unsigned y, int unsigned mo, int unsigned dy,
                                                int unsigned hr, int unsigned mi, int unsigned sc,
                                                int unsigned tz);
        return {2'b00, tz[4:0], sc[5:0], mi[5:0], hr[4:0], dy[4:0], mo[3:0], y[6:0]};
    endfunction

    function automatic t_reading reading(int unsigned y, int unsigned mo, int unsigned dy,
                                         int unsigned hr, int unsigned mi, int unsigned sc,
                                         logic [31:0] unix);
        t_reading r;
        r.cal.year   = y[6:0];
        r.cal.month  = mo[3:0];
        r.cal.day    = dy[4:0];
        r.cal.hour   = hr[4:0];
        r.cal.minute = mi[5:0];
        r.cal.second = sc[5:0];
        r.unix       = unix;
        return r;
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned mo);
        case (mo)
            2: begin
                return (y % 4 == 0) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic int unsigned days_ahead(int unsigned mo);
        case (mo)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic t_reading advance_clock(t_reading cur, ccu_pkg::t_cmd cmd,
                                               logic [39:0] d);
        t_reading          nxt;
        int unsigned       y, mo, dy, hr, mi, sc, tz, lim;
        longint unsigned   days, secs;
        nxt = cur;
        if (cmd == ccu_pkg::CMD_TICK) begin
            nxt.unix = cur.unix + 32'd1;
            if (cur.cal.second < 59) begin
                nxt.cal.second = cur.cal.second + 6'd1;
            end else begin
                nxt.cal.second = '0;
                if (cur.cal.minute < 59) begin
                    nxt.cal.minute = cur.cal.minute + 6'd1;
                end else begin
                    nxt.cal.minute = '0;
                    if (cur.cal.hour < 23) begin
                        nxt.cal.hour = cur.cal.hour + 5'd1;
                    end else begin
                        nxt.cal.hour = '0;
                        if (cur.cal.day < month_days(cur.cal.year, cur.cal.month)) begin
                            nxt.cal.day = cur.cal.day + 5'd1;
                        end else begin
                            nxt.cal.day = 5'd1;
                            if (cur.cal.month < 12) begin
                                nxt.cal.month = cur.cal.month + 4'd1;
                            end else begin
                                nxt.cal.month = 4'd1;
                                nxt.cal.year  = (cur.cal.year >= 99) ? 7'd0 : cur.cal.year + 7'd1;
                            end
                        end
                    end
                end
            end
        end else begin
            y  = d[6:0];
            mo = d[10:7];
            dy = d[15:11];
            hr = d[20:16];
            mi = d[26:21];
            sc = d[32:27];
            tz = d[37:33];
            if (y > 99) y = 99;
            if (mo < 1) mo = 1;
            if (mo > 12) mo = 12;
            lim = month_days(y, mo);
            if (dy < 1) dy = 1;
            if (dy > lim) dy = lim;
            if (hr > 23) hr = 23;
            if (mi > 59) mi = 59;
            if (sc > 59) sc = 59;
            days = 64'd10957 + 365 * y + (y + 3) / 4 + days_ahead(mo) + dy - 1;
            if (mo > 2 && y % 4 == 0) days = days + 1;
            secs = days * 64'd86400 + hr * 3600 + mi * 60 + sc;
            secs = secs - longint'(tz) * 3600;
            nxt = reading(y, mo, dy, hr, mi, sc, secs[31:0]);
        end
        return nxt;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_row(ccu_pkg::t_cmd cmd, logic [39:0] fields, bit typed, t_reading r);
        t_stim_row row;
        row.cmd     = cmd;
        row.fields  = fields;
        row.typed   = typed;
        row.reading = r;
        stim_table.push_back(row);
    endtask

    task automatic push_word(ccu_pkg::t_cmd cmd, logic [39:0] d);
        bit idle;
        idle = 1'b1;
        while (idle) begin
            case (phase)
                1:       idle = ($urandom_range(0, 99) < 71);
                3:       idle = ($urandom_range(0, 99) < 19);
                default: idle = 1'b0;
            endcase
            if (idle) begin
                s_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        case (phase)
            2:       m_ready <= ($urandom_range(0, 99) >= 71);
            3:       m_ready <= ($urandom_range(0, 99) >= 19);
            default: m_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : monitor
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            rtc_now = reading(0, 1, 1, 0, 0, 0, ccu_pkg::UNIX_RESET);
        end else begin
            if (s_valid && o_s_axis_tready) begin
                rtc_now = advance_clock(rtc_now, ccu_pkg::t_cmd'(s_user), s_data);
                pending_readings.push_back(cur_typed ? cur_reading : rtc_now);
            end
            if (o_m_axis_tvalid && m_ready) begin
                got = reading(o_m_axis_tdata[6:0], o_m_axis_tdata[10:7], o_m_axis_tdata[15:11],
                              o_m_axis_tdata[20:16], o_m_axis_tdata[26:21],
                              o_m_axis_tdata[32:27], o_m_axis_tdata[64:33]);
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time,
                             o_m_axis_tdata);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("year", want.cal.year, got.cal.year);
                    check_field("month", want.cal.month, got.cal.month);
                    check_field("day", want.cal.day, got.cal.day);
                    check_field("hour", want.cal.hour, got.cal.hour);
                    check_field("minute", want.cal.minute, got.cal.minute);
                    check_field("second", want.cal.second, got.cal.second);
                    check_field("unix_seconds", want.unix, got.unix);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned y, mo, dy, hr, mi, sc, tz;
        int          n, k, r;
        logic [39:0] d;
        i_rst_n     = 1'b0;
        s_valid     = 1'b0;
        s_user      = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cur_typed   = 1'b0;
        cur_reading = '0;
        phase       = 0;
        errors      = 0;
        cycle_cnt   = 0;

        add_row(ccu_pkg::CMD_TICK, pack_fields(0, 0, 0, 0, 0, 0, 0), 1,
                reading(0, 1, 1, 0, 0, 1, 32'd946684801));
        add_row(ccu_pkg::CMD_TICK, {2'b00, {38{1'b1}}}, 1,
                reading(0, 1, 1, 0, 0, 2, 32'd946684802));
        add_row(ccu_pkg::CMD_SET, pack_fields(99, 12, 31, 23, 59, 59, 0), 1,
                reading(99, 12, 31, 23, 59, 59, 32'd4102444799));
        add_row(ccu_pkg::CMD_TICK, pack_fields(0, 0, 0, 0, 0, 0, 0), 1,
                reading(0, 1, 1, 0, 0, 0, 32'd4102444800));
        add_row(ccu_pkg::CMD_SET, pack_fields(127, 15, 31, 31, 63, 63, 31), 1,
                reading(99, 12, 31, 23, 59, 59, 32'd4102333199));
        add_row(ccu_pkg::CMD_SET, pack_fields(0, 0, 0, 0, 0, 0, 31), 1,
                reading(0, 1, 1, 0, 0, 0, 32'd946573200));
        add_row(ccu_pkg::CMD_SET, pack_fields(0, 0, 0, 0, 0, 0, 0), 1,
                reading(0, 1, 1, 0, 0, 0, 32'd946684800));
        add_row(ccu_pkg::CMD_SET, pack_fields(4, 2, 31, 23, 59, 59, 24), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(1, 2, 30, 23, 59, 59, 5), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(3, 4, 31, 23, 59, 59, 1), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(20, 12, 31, 23, 59, 59, 8), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(10, 6, 15, 12, 59, 59, 12), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(50, 1, 31, 23, 59, 58, 16), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(50, 0, 15, 24, 60, 60, 2), 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(24, 2, 28, 23, 59, 59, 0), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);
        add_row(ccu_pkg::CMD_SET, pack_fields(24, 2, 29, 23, 59, 59, 0), 0, '0);
        add_row(ccu_pkg::CMD_TICK, '0, 0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[i]) begin
            cur_typed   = stim_table[i].typed;
            cur_reading = stim_table[i].reading;
            push_word(stim_table[i].cmd, stim_table[i].fields);
        end

        cur_typed = 1'b0;
        n = 0;
        while (n < RANDOM_WORDS) begin
            phase = (n * 4) / RANDOM_WORDS;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                y  = $urandom_range(0, 99);
                mo = $urandom_range(1, 12);
                dy = $urandom_range(0, 1) ? month_days(y, mo) : $urandom_range(1, 31);
                hr = ($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23);
                mi = ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59);
                sc = $urandom_range(45, 59);
                tz = $urandom_range(0, 24);
                if ($urandom_range(0, 9) == 0) begin
                    y  = 99;
                    mo = 12;
                    dy = 31;
                    hr = 23;
                    mi = 59;
                end
                push_word(ccu_pkg::CMD_SET, pack_fields(y, mo, dy, hr, mi, sc, tz));
                n++;
                k = $urandom_range(1, 20);
                repeat (k) begin
                    d = 40'({$urandom, $urandom});
                    d[39:38] = 2'b00;
                    push_word(ccu_pkg::CMD_TICK, d);
                    n++;
                end
            end else begin
                d = 40'({$urandom, $urandom});
                d[39:38] = 2'b00;
                push_word((r < 85) ? ccu_pkg::CMD_SET : ccu_pkg::CMD_TICK, d);
                n++;
            end
        end
        s_valid <= 1'b0;

        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== calendar_clock_with_unix_time.f =====
+incdir+rtl
rtl/ccu_pkg.sv
rtl/ccu_set_prep.sv
rtl/ccu_day_scale.sv
rtl/ccu_cal_core.sv
rtl/calendar_clock_with_unix_time.sv
rtl/ccu_port_checker.sv
sim/tb.sv
